// ===== hw/rtl/nroot_pkg.sv =====
// nroot_pkg: widths, microcode types and the control program of the exact n-th root unit
// depends on nothing; used by the interfaces, the sequencer and the top level
package nroot_pkg;

	// field widths and limits
	localparam int VALUE_BITS   = 31;
	localparam int MAX_EXPONENT = 63;
	localparam int EXP_W        = 6;
	localparam int PROD_W       = 2 * VALUE_BITS;
	localparam int STEP_W       = 3;

	typedef logic [STEP_W-1:0] step_t;

	// datapath actions, one per control word
	typedef enum logic [2:0] {
		A_LOAD,
		A_MID,
		A_MUL,
		A_ACC,
		A_LOW,
		A_HIGH,
		A_EMIT_NO,
		A_EMIT_HIT
	} act_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_IN_VALID,
		C_EMPTY,
		C_K_DONE,
		C_PROD_GT,
		C_ACC_EQ,
		C_OUT_FREE,
		C_ALWAYS
	} cond_t;

	// one control word: action, condition, target when true, target when false
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t jt;
		step_t jf;
	} uword_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic empty;
		logic k_done;
		logic prod_gt;
		logic acc_eq;
		logic out_free;
	} flags_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		act_t act;
		logic hit;
	} ctrl_t;

	// program step addresses
	localparam step_t S_WAIT     = 3'd0;
	localparam step_t S_MID      = 3'd1;
	localparam step_t S_MUL      = 3'd2;
	localparam step_t S_ACC      = 3'd3;
	localparam step_t S_LOW      = 3'd4;
	localparam step_t S_HIGH     = 3'd5;
	localparam step_t S_EMIT_NO  = 3'd6;
	localparam step_t S_EMIT_HIT = 3'd7;

	// control store
	function automatic uword_t ucode(step_t pc);
		uword_t w;
		unique case (pc)
			S_WAIT:     w = '{A_LOAD,     C_IN_VALID, S_MID,      S_WAIT};
			S_MID:      w = '{A_MID,      C_EMPTY,    S_EMIT_NO,  S_MUL};
			S_MUL:      w = '{A_MUL,      C_K_DONE,   S_LOW,      S_ACC};
			S_ACC:      w = '{A_ACC,      C_PROD_GT,  S_HIGH,     S_MUL};
			S_LOW:      w = '{A_LOW,      C_ACC_EQ,   S_EMIT_HIT, S_MID};
			S_HIGH:     w = '{A_HIGH,     C_ALWAYS,   S_MID,      S_MID};
			S_EMIT_NO:  w = '{A_EMIT_NO,  C_OUT_FREE, S_WAIT,     S_EMIT_NO};
			S_EMIT_HIT: w = '{A_EMIT_HIT, C_OUT_FREE, S_WAIT,     S_EMIT_HIT};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/nroot_if.sv =====
// nroot_in_if and nroot_out_if: valid/ready channels of the exact n-th root unit
// depends on nroot_pkg for field widths
interface nroot_in_if import nroot_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [EXP_W-1:0]      exponent;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output exponent, output value, input ready);
	modport sink   (input valid, input exponent, input value, output ready);
endinterface

interface nroot_out_if import nroot_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [VALUE_BITS-1:0] root;

	modport source (output valid, output found, output root, input ready);
	modport sink   (input valid, input found, input root, output ready);
endinterface

// ===== hw/rtl/integer_nth_root_exact_unit.sv =====
// integer_nth_root_exact_unit: top level, search datapath and result register
// depends on nroot_pkg, nroot_if (channels) and nroot_seq (control sequencer)
//
// usage
//   req carries an item (exponent n, value m); rsp returns one item per request:
//   found=1 and the root r with r**n == m, or found=0 and root 0.
//   both channels use valid/ready; an item moves when both are high at a clock edge.
//   one request is worked on at a time; req.ready is high only while the
//   sequencer waits at its first step.
// sequence
//   the first step takes the item; each binary search step computes the midpoint,
//   runs each multiplication on the one shared 31x31 multiplier (registered product,
//   then compare), sees the count done and moves the interval: at most 31 steps;
//   on a miss a final midpoint step finds the interval empty; then the result
//   is written. the early exit on overshoot usually cuts the multiplications
//   far below n.
// reset
//   arst_n clears the step counter and the result valid flag; no item is lost
//   or invented after reset.
// stall
//   a finished result sits in the result register; the next request is
//   already taken and searched while it waits, and only the write of the next
//   result holds until rsp.ready frees the register.
module integer_nth_root_exact_unit import nroot_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nroot_in_if.sink    req,
	nroot_out_if.source rsp
);

	ctrl_t  ctrl;
	flags_t flags;

	logic [EXP_W-1:0]      n_q;
	logic [VALUE_BITS-1:0] m_q;
	logic [VALUE_BITS:0]   low_q;
	logic [VALUE_BITS-1:0] high_q;
	logic [VALUE_BITS-1:0] mid_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [PROD_W-1:0]     prod_q;
	logic [EXP_W-1:0]      k_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [VALUE_BITS-1:0] out_root_q;

	logic [VALUE_BITS-1:0] diff;
	logic [VALUE_BITS-1:0] mid_calc;
	logic [EXP_W-1:0]      n_sat;
	logic                  out_free;

	// control sequencer
	nroot_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctrl  (ctrl)
	);

	// midpoint of the live interval, valid while low <= high
	assign diff     = high_q - low_q[VALUE_BITS-1:0];
	assign mid_calc = low_q[VALUE_BITS-1:0] + (diff >> 1);

	// exponent clamp
	always_comb begin
		if (int'(req.exponent) > MAX_EXPONENT) begin
			n_sat = EXP_W'(MAX_EXPONENT);
		end else begin
			n_sat = req.exponent;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	// status flags
	always_comb begin
		flags.in_valid = req.valid;
		flags.empty    = low_q > {1'b0, high_q};
		flags.k_done   = k_q == n_q;
		flags.prod_gt  = prod_q > {{VALUE_BITS{1'b0}}, m_q};
		flags.acc_eq   = acc_q == m_q;
		flags.out_free = out_free;
	end

	assign req.ready = ctrl.act == A_LOAD;

	// search datapath
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			A_LOAD: begin
				if (ctrl.hit) begin
					n_q    <= n_sat;
					m_q    <= req.value;
					low_q  <= (VALUE_BITS+1)'(1);
					high_q <= req.value;
				end
			end
			A_MID: begin
				mid_q <= mid_calc;
				acc_q <= VALUE_BITS'(1);
				k_q   <= '0;
			end
			A_MUL: begin
				prod_q <= PROD_W'(acc_q) * PROD_W'(mid_q);
				k_q    <= k_q + EXP_W'(1);
			end
			A_ACC: begin
				if (!ctrl.hit) begin
					acc_q <= prod_q[VALUE_BITS-1:0];
				end
			end
			A_LOW: begin
				if (!ctrl.hit) begin
					low_q <= {1'b0, mid_q} + (VALUE_BITS+1)'(1);
				end
			end
			A_HIGH: begin
				high_q <= mid_q - VALUE_BITS'(1);
			end
			A_EMIT_NO, A_EMIT_HIT: begin
			end
		endcase
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.act == A_EMIT_NO || ctrl.act == A_EMIT_HIT) && ctrl.hit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if ((ctrl.act == A_EMIT_NO || ctrl.act == A_EMIT_HIT) && ctrl.hit) begin
			out_found_q <= ctrl.act == A_EMIT_HIT;
			out_root_q  <= (ctrl.act == A_EMIT_HIT) ? mid_q : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.root  = out_root_q;

`ifndef NO_ASSERTIONS
	// partial power never passes m before the next multiplication
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.act == A_MUL |-> acc_q <= m_q)
		else $error("partial power above value at multiply step");

	// multiplication count never runs past the exponent
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == A_MUL || ctrl.act == A_ACC) |-> k_q <= n_q)
		else $error("multiplication count past exponent");

	// the candidate stays inside the search interval
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.act == A_ACC |-> ({1'b0, mid_q} >= low_q && mid_q <= high_q))
		else $error("candidate outside search interval");

	// a found root is never zero, a miss always reports zero
	a_root_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.found ? rsp.root != '0 : rsp.root == '0))
		else $error("root does not match found flag");
`endif

endmodule

// ===== hw/rtl/nroot_seq.sv =====
// nroot_seq: step counter and control store walk of the exact n-th root unit
// depends on nroot_pkg for the program and the control types
module nroot_seq import nroot_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	step_t  pc_q;
	step_t  pc_next;
	uword_t word;
	logic   hit;

	// fetch the current control word
	assign word = ucode(pc_q);

	// evaluate the jump condition
	always_comb begin
		unique case (word.cond)
			C_IN_VALID: hit = flags.in_valid;
			C_EMPTY:    hit = flags.empty;
			C_K_DONE:   hit = flags.k_done;
			C_PROD_GT:  hit = flags.prod_gt;
			C_ACC_EQ:   hit = flags.acc_eq;
			C_OUT_FREE: hit = flags.out_free;
			C_ALWAYS:   hit = 1'b1;
			default:    hit = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		pc_next = hit ? word.jt : word.jf;
	end

	// control out to the datapath
	always_comb begin
		ctrl.act = word.act;
		ctrl.hit = hit;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== tb/sv/tb_integer_nth_root_exact_unit.sv =====
// tb_integer_nth_root_exact_unit: self-checking bench for the exact n-th root unit
// drives directed and random (exponent, value) items and checks every result against typed-in
// values or a binary search predictor; depends on nroot_pkg, nroot_if and the unit itself
module tb_integer_nth_root_exact_unit;
	import nroot_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned VMAX = (64'd1 << VALUE_BITS) - 1;
	localparam int N_RANDOM    = 265;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 200;
	localparam int CYCLE_LIMIT = 6_000_000;

	// one expected result, with the item that caused it for reporting
	typedef struct packed {
		logic [EXP_W-1:0]      n;
		logic [VALUE_BITS-1:0] m;
		logic                  found;
		logic [VALUE_BITS-1:0] root;
	} root_case_t;

	// directed row: fixed=1 means found/root are typed in, else predicted
	typedef struct packed {
		logic [EXP_W-1:0]      n;
		logic [VALUE_BITS-1:0] m;
		logic                  fixed;
		logic                  found;
		logic [VALUE_BITS-1:0] root;
	} probe_t;

	localparam int N_PROBES = 25;
	localparam probe_t PROBES [0:N_PROBES-1] = '{
		// zero value: empty search interval
		'{6'd1,  31'd0,          1'b1, 1'b0, 31'd0},
		'{6'd63, 31'd0,          1'b1, 1'b0, 31'd0},
		'{6'd0,  31'd0,          1'b1, 1'b0, 31'd0},
		// zero exponent: only a value of one has a root
		'{6'd0,  31'd1,          1'b1, 1'b1, 31'd1},
		'{6'd0,  31'd2,          1'b1, 1'b0, 31'd0},
		'{6'd0,  31'h7FFFFFFF,   1'b1, 1'b0, 31'd0},
		// value one: root one at any exponent
		'{6'd1,  31'd1,          1'b1, 1'b1, 31'd1},
		'{6'd63, 31'd1,          1'b1, 1'b1, 31'd1},
		// extremes of value and exponent
		'{6'd1,  31'h7FFFFFFF,   1'b1, 1'b1, 31'h7FFFFFFF},
		'{6'd2,  31'd2147395600, 1'b1, 1'b1, 31'd46340},
		'{6'd3,  31'd2146689000, 1'b1, 1'b1, 31'd1290},
		'{6'd30, 31'd1073741824, 1'b1, 1'b1, 31'd2},
		'{6'd2,  31'd1073741824, 1'b1, 1'b1, 31'd32768},
		'{6'd63, 31'h7FFFFFFF,   1'b1, 1'b0, 31'd0},
		// near misses, exact powers and assorted bit patterns, all predicted
		'{6'd30, 31'd1073741825, 1'b0, 1'b0, 31'd0},
		'{6'd2,  31'd2147395601, 1'b0, 1'b0, 31'd0},
		'{6'd31, 31'h7FFFFFFF,   1'b0, 1'b0, 31'd0},
		'{6'd5,  31'd243,        1'b0, 1'b0, 31'd0},
		'{6'd7,  31'd128,        1'b0, 1'b0, 31'd0},
		'{6'd2,  31'd2,          1'b0, 1'b0, 31'd0},
		'{6'h2A, 31'h55555555,   1'b0, 1'b0, 31'd0},
		'{6'h15, 31'h2AAAAAAA,   1'b0, 1'b0, 31'd0},
		'{6'd1,  31'h40000000,   1'b0, 1'b0, 31'd0},
		'{6'd16, 31'd65536,      1'b0, 1'b0, 31'd0},
		'{6'd10, 31'd59049,      1'b0, 1'b0, 31'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	nroot_in_if  req();
	nroot_out_if rsp();

	integer_nth_root_exact_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	root_case_t pending_roots [$];
	int  err_cnt   = 0;
	int  sent_cnt  = 0;
	int  got_cnt   = 0;
	int  hit_cnt   = 0;
	int  zero_exp  = 0;
	int  cycle_cnt = 0;
	bit  no_gaps   = 1'b0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// base**n, or lim+1 once the running product passes lim
	function automatic longint unsigned capped_power(longint unsigned base, longint unsigned n,
			longint unsigned lim);
		longint unsigned acc;
		acc = 1;
		for (longint unsigned k = 0; k < n; k++) begin
			if (acc > lim / base)
				return lim + 1;
			acc = acc * base;
		end
		return acc;
	endfunction

	// binary search for r in [1, m] with r**n == m
	function automatic root_case_t exact_root(logic [EXP_W-1:0] n, logic [VALUE_BITS-1:0] m);
		root_case_t res;
		longint unsigned lo, hi, mid, p, nn, mm;
		res = '0;
		res.n = n;
		res.m = m;
		nn = n;
		mm = m;
		if (nn > MAX_EXPONENT)
			nn = MAX_EXPONENT;
		lo = 1;
		hi = mm;
		while (lo <= hi && !res.found) begin
			mid = lo + (hi - lo) / 2;
			p = capped_power(mid, nn, mm);
			if (p == mm) begin
				res.found = 1'b1;
				res.root  = mid[VALUE_BITS-1:0];
			end else if (p < mm) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return res;
	endfunction

	// random idle decision, off during the calm stretch
	function automatic bit gap_now();
		return !no_gaps && ($urandom_range(99) < 18);
	endfunction

	// present one item, hold it until taken, then queue its expected result
	task automatic offer(logic [EXP_W-1:0] n, logic [VALUE_BITS-1:0] m, bit fixed,
			logic found, logic [VALUE_BITS-1:0] root);
		root_case_t want;
		while (gap_now()) begin
			req.valid    <= 1'b0;
			req.exponent <= EXP_W'($urandom());
			req.value    <= VALUE_BITS'($urandom());
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.exponent <= n;
		req.value    <= m;
		do @(posedge clk); while (!req.ready);
		if (fixed)
			want = '{n, m, found, root};
		else
			want = exact_root(n, m);
		pending_roots.push_back(want);
		sent_cnt++;
		if (n == '0)
			zero_exp++;
	endtask

	// stimulus: reset, directed table, then random items
	initial begin
		longint unsigned r, m;
		int e, bits, kind;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.exponent <= '0;
		req.value    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			offer(PROBES[i].n, PROBES[i].m, PROBES[i].fixed, PROBES[i].found, PROBES[i].root);

		for (int i = 0; i < N_RANDOM; i++) begin
			no_gaps = (i >= 120 && i < 170);
			kind = $urandom_range(99);
			if (kind < 60) begin
				// a true power, sometimes nudged by one
				e = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 63);
				bits = $urandom_range(1, VALUE_BITS);
				r = $urandom_range(1, 32'((64'd1 << bits) - 1));
				while (capped_power(r, e, VMAX) > VMAX)
					r = r >> 1;
				m = capped_power(r, e, VMAX);
				case ($urandom_range(3))
					0: if (m < VMAX) m = m + 1;
					1: m = m - 1;
					default: ;
				endcase
			end else if (kind < 85) begin
				// noise over the whole field range
				e = $urandom_range(0, 63);
				bits = $urandom_range(1, VALUE_BITS);
				m = $urandom() & ((64'd1 << bits) - 1);
			end else begin
				// tiny values at any exponent
				e = $urandom_range(0, 63);
				m = $urandom_range(0, 3);
			end
			offer(EXP_W'(e), VALUE_BITS'(m), 1'b0, 1'b0, '0);
		end
		no_gaps = 1'b0;
		req.valid <= 1'b0;

		// drain, then watch for stray results
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d items sent (%0d directed, %0d with exponent zero), %0d results checked,",
			sent_cnt, N_PROBES, zero_exp, got_cnt);
		$display("%0d exact roots reported, receiver held off twice for %0d cycles",
			hit_cnt, HOLD_CYCLES);
		if (err_cnt == 0)
			$display("integer_nth_root_exact_unit: match");
		else
			$display("integer_nth_root_exact_unit: mismatch");
		$finish;
	end

	// result side: random ready, two long hold-offs, compare with the oldest expectation
	initial begin : result_side
		int hold_left;
		int holds_done;
		root_case_t want;
		hold_left  = 0;
		holds_done = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got_cnt++;
				if (rsp.found)
					hit_cnt++;
				if (pending_roots.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got found=%0d root=%0d",
						$time, rsp.found, rsp.root);
				end else begin
					want = pending_roots.pop_front();
					if (rsp.found !== want.found) begin
						err_cnt++;
						$display("%0t: found wrong for n=%0d m=%0d, expected %0d, got %0d",
							$time, want.n, want.m, want.found, rsp.found);
					end
					if (rsp.root !== want.root) begin
						err_cnt++;
						$display("%0t: root wrong for n=%0d m=%0d, expected %0d, got %0d",
							$time, want.n, want.m, want.root, rsp.root);
					end
				end
			end
			if (hold_left == 0 && holds_done < 2 && sent_cnt >= 60 + 120 * holds_done) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !gap_now();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_roots.size());
			$display("integer_nth_root_exact_unit: mismatch");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
hw/rtl/nroot_pkg.sv
hw/rtl/nroot_if.sv
hw/rtl/nroot_seq.sv
hw/rtl/integer_nth_root_exact_unit.sv
tb/sv/tb_integer_nth_root_exact_unit.sv
